// ===== rtl/overlay_slot_fade_manager_macros.svh =====
// Assertion macros shared by the overlay slot fade manager RTL.
`ifndef OVERLAY_SLOT_FADE_MANAGER_MACROS_SVH
`define OVERLAY_SLOT_FADE_MANAGER_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define OSFM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define OSFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/osfm_pkg.sv =====
// Types, codes and constants of the overlay slot fade manager.
`default_nettype none

package osfm_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int MAX_REPORTS    = 8;
  localparam int RPT_W          = $clog2(MAX_REPORTS + 1);
  localparam int ALPHA_FRAC     = 8;
  localparam int TIME_W         = 31;
  localparam int FADE_W         = 16;
  localparam int ID_W           = 8;
  localparam int SLOT_OUT_W     = 3;
  localparam logic [FADE_W-1:0] FADE_RESET = 16'd200;
  localparam logic [8:0]        ALPHA_FULL = 9'd256;

  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] KIND_OPEN   = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_IN  = 2'd1,
    MODE_ON  = 2'd2,
    MODE_OUT = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ID_W-1:0]   window_id;
    logic [FADE_W-1:0] auto_close_ms;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [ID_W-1:0]       shown_id;
    logic [1:0]            shown_state;
    logic [8:0]            alpha_q8;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    mode_t             mode;
    logic [TIME_W-1:0] start;
    logic [FADE_W-1:0] auto_close;
  } slot_entry_t;

  typedef struct packed {
    logic              start;
    logic [FADE_W-1:0] num;
    logic [FADE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [ALPHA_FRAC-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/osfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module osfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/osfm_div.sv =====
// Radix-2 restoring divider for the Q8 opacity fraction, one bit per cycle.
`default_nettype none
`include "overlay_slot_fade_manager_macros.svh"

module osfm_div
  import osfm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEP_W = (ALPHA_FRAC > 1) ? $clog2(ALPHA_FRAC) : 1;

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_W-1:0]     step_r;
  logic [FADE_W-1:0]     rem_r;
  logic [FADE_W-1:0]     den_r;
  logic [ALPHA_FRAC-1:0] quot_r;
  logic [FADE_W:0]       shl;
  logic                  fits;
  logic                  last_step;

  // num < den on entry, so the shifted remainder stays below 2*den.
  assign shl       = {rem_r, 1'b0};
  assign fits      = shl >= {1'b0, den_r};
  assign last_step = step_r == STEP_W'(ALPHA_FRAC - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? FADE_W'(shl - {1'b0, den_r}) : shl[FADE_W-1:0];
      quot_r <= {quot_r[ALPHA_FRAC-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  `OSFM_ASSERT_SAME(a_div_no_restart, req.start, !busy_r, "divider started while busy")
  `OSFM_ASSERT_NEXT(a_div_starts, req.start, busy_r, "divider did not start")
  `OSFM_ASSERT_SAME(a_div_done_idle, done_r, !busy_r, "divider done while still busy")

endmodule

`default_nettype wire

// ===== rtl/overlay_slot_fade_manager.sv =====
// Top level of the overlay slot fade manager: sequencer around the slot table RAM.
// Every transaction walks all SLOTS slots in turn, reading each and then evaluating it.
// A tick also pushes each reported slot and waits on the divider while a fade divides.
// Throughput: one transaction at a time; the next is taken in the idle cycle after finish.
// The pace is set by the single RAM read port, walked one slot per read, and the divider.
// Reset (rst_n, synchronous): all slots off via per-slot valid bits, fade time 200 ms.
`default_nettype none
`include "overlay_slot_fade_manager_macros.svh"

module overlay_slot_fade_manager
  import osfm_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input transactions
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  // result transactions
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  // fade time register
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [FADE_W-1:0] cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,  // read slot idx_r
    ST_EVAL = 6'b000100,  // slot data on RAM output, update and write back
    ST_DIV  = 6'b001000,  // wait for alpha fraction
    ST_PUSH = 6'b010000,  // move candidate report into the hold slot
    ST_FIN  = 6'b100000   // issue final result of the transaction
  } state_t;

  state_t st_r, st_nxt;

  // configuration and table bookkeeping
  logic [FADE_W-1:0] fade_r;
  logic [SLOTS-1:0]  valid_r;
  logic              rd_vld_r;
  logic [IW-1:0]     idx_r;
  logic              idx_last;
  in_item_t          item_r;

  // open scan trackers
  logic              match_found_r, free_found_r;
  logic [IW-1:0]     match_idx_r, free_idx_r, min_idx_r, pick;
  logic [TIME_W-1:0] min_time_r;

  // close scan trackers
  logic              close_found_r;
  logic [IW-1:0]     close_idx_r;

  // tick reports: the held one waits until we know whether it is the last
  out_item_t         cand_r, hold_r, out_r;
  logic              hold_vld_r, out_vld_r, out_free;
  logic [RPT_W-1:0]  rpt_cnt_r;

  // RAM ports
  slot_entry_t       ram_rdata, ram_wdata, ent, ev_wentry, open_entry;
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr;

  // slot evaluation
  logic              live, id_hit, ft_hit, ac_hit;
  logic [TIME_W-1:0] el;
  logic              tk_we, tk_report, tk_need_div, tk_full;
  mode_t             tk_state;
  logic [FADE_W-1:0] tk_num;
  logic              ev_we, rpt_room;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  osfm_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  osfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = st_r != ST_IDLE;
  assign cfg_ready = st_r == ST_IDLE;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign out_free  = !out_vld_r || !out_stall;
  assign idx_last  = idx_r == IW'(SLOTS - 1);
  assign ram_re    = st_r == ST_RD;
  assign rpt_room  = rpt_cnt_r < RPT_W'(MAX_REPORTS);

  // Never-written slots read as all zero, i.e. off.
  assign ent    = rd_vld_r ? ram_rdata : '0;
  assign live   = ent.mode != MODE_OFF;
  assign id_hit = live && (ent.id == item_r.window_id);
  // elapsed time, clamped at zero
  assign el     = (item_r.now_ms > ent.start) ? TIME_W'(item_r.now_ms - ent.start) : '0;
  assign ft_hit = el >= TIME_W'(fade_r);
  assign ac_hit = (ent.auto_close != '0) && (el >= TIME_W'(ent.auto_close));

  assign pick = match_found_r ? match_idx_r : (free_found_r ? free_idx_r : min_idx_r);

  // Per-slot tick step.
  always_comb begin
    tk_we       = 1'b0;
    tk_report   = 1'b0;
    tk_need_div = 1'b0;
    tk_full     = 1'b0;
    tk_state    = ent.mode;
    tk_num      = '0;
    ev_wentry   = ent;
    case (ent.mode)
      MODE_IN: begin
        tk_report = 1'b1;
        if (ft_hit) begin
          tk_we           = 1'b1;
          ev_wentry.mode  = MODE_ON;
          ev_wentry.start = item_r.now_ms;
          tk_state        = MODE_ON;
          tk_full         = 1'b1;
        end else begin
          tk_need_div = 1'b1;
          tk_num      = el[FADE_W-1:0];
        end
      end
      MODE_ON: begin
        tk_report = 1'b1;
        tk_full   = 1'b1;
        if (ac_hit) begin
          tk_we           = 1'b1;
          ev_wentry.mode  = MODE_OUT;
          ev_wentry.start = item_r.now_ms;
          tk_state        = MODE_OUT;
        end
      end
      MODE_OUT: begin
        if (ft_hit) begin
          // faded out: back to off, not reported
          tk_we          = 1'b1;
          ev_wentry.mode = MODE_OFF;
        end else if (el == '0) begin
          // fade-out has not started yet: still fully opaque
          tk_report = 1'b1;
          tk_full   = 1'b1;
        end else begin
          tk_report   = 1'b1;
          tk_need_div = 1'b1;
          tk_num      = fade_r - el[FADE_W-1:0];
        end
      end
      default: begin
      end
    endcase
    // a close reuses the same write path
    if (item_r.opcode == OP_CLOSE) begin
      ev_wentry       = ent;
      ev_wentry.mode  = MODE_OUT;
      ev_wentry.start = item_r.now_ms;
    end
  end

  assign ev_we = ((item_r.opcode == OP_CLOSE) && id_hit) ||
                 ((item_r.opcode == OP_TICK) && tk_we);

  always_comb begin
    open_entry.id         = item_r.window_id;
    open_entry.mode       = MODE_IN;
    open_entry.start      = item_r.now_ms;
    open_entry.auto_close = item_r.auto_close_ms;
  end

  // Writes to slot idx_r land after its read; the next read is a later slot,
  // and the open write-back comes after the whole scan, so no forwarding.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ev_wentry;
    if (st_r == ST_EVAL) begin
      ram_we = ev_we;
    end else if ((st_r == ST_FIN) && (item_r.opcode == OP_OPEN) && out_free) begin
      ram_we    = 1'b1;
      ram_waddr = pick;
      ram_wdata = open_entry;
    end
  end

  assign div_req.start = (st_r == ST_EVAL) && (item_r.opcode == OP_TICK) &&
                         tk_report && tk_need_div && rpt_room;
  assign div_req.num   = tk_num;
  assign div_req.den   = fade_r;

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        st_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (div_req.start) begin
          st_nxt = ST_DIV;
        end else if ((item_r.opcode == OP_TICK) && tk_report && rpt_room) begin
          st_nxt = ST_PUSH;
        end else begin
          st_nxt = idx_last ? ST_FIN : ST_RD;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          st_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!hold_vld_r || out_free) begin
          st_nxt = idx_last ? ST_FIN : ST_RD;
        end
      end
      ST_FIN: begin
        if (out_free || ((item_r.opcode == OP_TICK) && !hold_vld_r) ||
            (item_r.opcode != OP_OPEN && item_r.opcode != OP_CLOSE &&
             item_r.opcode != OP_TICK)) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      fade_r        <= FADE_RESET;
      valid_r       <= '0;
      rd_vld_r      <= 1'b0;
      idx_r         <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      close_found_r <= 1'b0;
      hold_vld_r    <= 1'b0;
      out_vld_r     <= 1'b0;
      rpt_cnt_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        fade_r <= cfg_data;
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            idx_r         <= '0;
            match_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            close_found_r <= 1'b0;
            hold_vld_r    <= 1'b0;
            rpt_cnt_r     <= '0;
          end
        end
        ST_RD: begin
          rd_vld_r <= valid_r[idx_r];
        end
        ST_EVAL: begin
          if ((item_r.opcode == OP_OPEN) && id_hit && !match_found_r) begin
            match_found_r <= 1'b1;
          end
          if ((item_r.opcode == OP_OPEN) && !live && !free_found_r) begin
            free_found_r <= 1'b1;
          end
          if ((item_r.opcode == OP_CLOSE) && id_hit && !close_found_r) begin
            close_found_r <= 1'b1;
          end
          if ((st_nxt == ST_RD) && !idx_last) begin
            idx_r <= idx_r + IW'(1);
          end
        end
        ST_PUSH: begin
          if (!hold_vld_r || out_free) begin
            if (hold_vld_r) begin
              out_vld_r <= 1'b1;
            end
            hold_vld_r <= 1'b1;
            rpt_cnt_r  <= rpt_cnt_r + RPT_W'(1);
            if (!idx_last) begin
              idx_r <= idx_r + IW'(1);
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            if ((item_r.opcode == OP_OPEN) || (item_r.opcode == OP_CLOSE) ||
                ((item_r.opcode == OP_TICK) && hold_vld_r)) begin
              out_vld_r <= 1'b1;
            end
            hold_vld_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((st_r == ST_IDLE) && in_valid) begin
      item_r <= in_data;
    end
    if ((st_r == ST_EVAL) && (item_r.opcode == OP_OPEN)) begin
      if (id_hit && !match_found_r) begin
        match_idx_r <= idx_r;
      end
      if (!live && !free_found_r) begin
        free_idx_r <= idx_r;
      end
      // earliest start wins, lowest index on a tie
      if ((idx_r == '0) || (ent.start < min_time_r)) begin
        min_idx_r  <= idx_r;
        min_time_r <= ent.start;
      end
    end
    if ((st_r == ST_EVAL) && (item_r.opcode == OP_CLOSE) && id_hit && !close_found_r) begin
      close_idx_r <= idx_r;
    end
    if (st_r == ST_EVAL) begin
      cand_r.kind        <= KIND_REPORT;
      cand_r.slot        <= SLOT_OUT_W'(idx_r);
      cand_r.shown_id    <= ent.id;
      cand_r.shown_state <= tk_state;
      cand_r.alpha_q8    <= tk_full ? ALPHA_FULL : '0;
      cand_r.last        <= 1'b0;
    end
    if ((st_r == ST_DIV) && div_rsp.done) begin
      cand_r.alpha_q8 <= {1'b0, div_rsp.quot};
    end
    if ((st_r == ST_PUSH) && (!hold_vld_r || out_free)) begin
      if (hold_vld_r) begin
        out_r <= hold_r;
      end
      hold_r <= cand_r;
    end
    if ((st_r == ST_FIN) && out_free) begin
      case (item_r.opcode)
        OP_OPEN: begin
          out_r.kind        <= KIND_OPEN;
          out_r.slot        <= SLOT_OUT_W'(pick);
          out_r.shown_id    <= item_r.window_id;
          out_r.shown_state <= MODE_IN;
          out_r.alpha_q8    <= '0;
          out_r.last        <= 1'b1;
        end
        OP_CLOSE: begin
          out_r.kind        <= KIND_CLOSE;
          out_r.slot        <= close_found_r ? SLOT_OUT_W'(close_idx_r) : '0;
          out_r.shown_id    <= item_r.window_id;
          out_r.shown_state <= close_found_r ? MODE_OUT : MODE_OFF;
          out_r.alpha_q8    <= '0;
          out_r.last        <= 1'b1;
        end
        OP_TICK: begin
          if (hold_vld_r) begin
            out_r      <= hold_r;
            out_r.last <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `OSFM_ASSERT_SAME(a_we_state, ram_we, (st_r == ST_EVAL) || (st_r == ST_FIN),
                    "slot table written outside eval or finish")
  `OSFM_ASSERT_SAME(a_div_done_state, div_rsp.done, st_r == ST_DIV,
                    "divider result arrived while not waiting")
  `OSFM_ASSERT_SAME(a_rpt_cap, 1'b1, rpt_cnt_r <= RPT_W'(MAX_REPORTS),
                    "report count beyond limit")
  `OSFM_ASSERT_SAME(a_idle_no_hold, st_r == ST_IDLE, !hold_vld_r,
                    "report left behind in hold slot")
  `OSFM_ASSERT_SAME(a_alpha_range, out_vld_r, out_r.alpha_q8 <= ALPHA_FULL,
                    "alpha above full opacity")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the overlay slot fade manager: directed cases, random traffic.
`timescale 1ns / 1ps

module testbench;
  import osfm_pkg::*;

  localparam int SLOT_COUNT = SLOTS_DEF;
  // The block ignores this opcode: no result, no change to the table.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Bounds the longest tick (per-slot reads, pushes and divides); rounded up for the drain.
  localparam int SETTLE_CYCLES = 128;
  // Length of the receiver hold-off in the backpressure test.
  localparam int HOLD_CYCLES = 400;
  localparam logic [31:0] TIME_MAX = 32'h7FFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  overlay_slot_fade_manager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the slot table and the fade time register.
  logic [7:0]  tbl_id    [SLOT_COUNT];
  mode_t       tbl_mode  [SLOT_COUNT];
  logic [30:0] tbl_start [SLOT_COUNT];
  logic [15:0] tbl_auto  [SLOT_COUNT];
  logic [15:0] fade_ms;

  // Slot results owed by the block, oldest first.
  out_item_t   due_slot_results [$];

  int          errors;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_requests;
  logic [31:0] wall_ms;        // running clock of the random traffic
  out_item_t   want_res;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net: the slowest legal run is far shorter than this.
  initial begin
    #6_000_000;
    $display("** overlay_slot_fade_manager: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
  endtask

  function automatic out_item_t make_result(input logic [1:0] kind, input int slot,
                                            input logic [7:0] id, input logic [1:0] state,
                                            input logic [8:0] alpha);
    out_item_t r;
    r = '0;
    r.kind        = kind;
    r.slot        = 3'(slot);
    r.shown_id    = id;
    r.shown_state = state;
    r.alpha_q8    = alpha;
    r.last        = 1'b0;
    return r;
  endfunction

  // Applies one transaction to the shadow table and queues the results it owes.
  function automatic void step_slot_table(input in_item_t it);
    int          pick;
    int          n;
    logic [31:0] el;
    logic [31:0] alpha;
    logic [31:0] ft;
    logic        shown;
    out_item_t   rep [MAX_REPORTS];
    out_item_t   r;
    ft = {16'd0, fade_ms};
    n  = 0;
    case (it.opcode)
      OP_OPEN: begin
        // same id already live, else first free slot, else the oldest start
        pick = -1;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (pick < 0 && tbl_mode[i] != MODE_OFF && tbl_id[i] == it.window_id) pick = i;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (pick < 0 && tbl_mode[i] == MODE_OFF) pick = i;
        if (pick < 0) begin
          pick = 0;
          for (int i = 1; i < SLOT_COUNT; i++)
            if (tbl_start[i] < tbl_start[pick]) pick = i;
        end
        tbl_id[pick]    = it.window_id;
        tbl_mode[pick]  = MODE_IN;
        tbl_start[pick] = it.now_ms;
        tbl_auto[pick]  = it.auto_close_ms;
        r = make_result(KIND_OPEN, pick, it.window_id, MODE_IN, 9'd0);
        r.last = 1'b1;
        due_slot_results.push_back(r);
      end
      OP_CLOSE: begin
        pick = -1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (tbl_mode[i] != MODE_OFF && tbl_id[i] == it.window_id) begin
            tbl_mode[i]  = MODE_OUT;
            tbl_start[i] = it.now_ms;
            if (pick < 0) pick = i;
          end
        end
        if (pick < 0) r = make_result(KIND_CLOSE, 0, it.window_id, MODE_OFF, 9'd0);
        else r = make_result(KIND_CLOSE, pick, it.window_id, MODE_OUT, 9'd0);
        r.last = 1'b1;
        due_slot_results.push_back(r);
      end
      OP_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (tbl_mode[i] != MODE_OFF) begin
            shown = 1'b1;
            alpha = 32'd0;
            el = (it.now_ms > tbl_start[i]) ? {1'b0, it.now_ms} - {1'b0, tbl_start[i]} : 32'd0;
            case (tbl_mode[i])
              MODE_IN: begin
                if (el >= ft) begin
                  tbl_mode[i]  = MODE_ON;
                  tbl_start[i] = it.now_ms;
                  alpha = 32'd256;
                end else begin
                  alpha = (el * 32'd256) / ft;
                end
              end
              MODE_ON: begin
                alpha = 32'd256;
                if (tbl_auto[i] != 16'd0 && el >= {16'd0, tbl_auto[i]}) begin
                  tbl_mode[i]  = MODE_OUT;
                  tbl_start[i] = it.now_ms;
                end
              end
              default: begin
                if (el >= ft) begin
                  tbl_mode[i] = MODE_OFF;
                  shown = 1'b0;
                end else begin
                  alpha = ((ft - el) * 32'd256) / ft;
                end
              end
            endcase
            if (shown && n < MAX_REPORTS) begin
              rep[n] = make_result(KIND_REPORT, i, tbl_id[i], tbl_mode[i], alpha[8:0]);
              n++;
            end
          end
        end
        for (int k = 0; k < n; k++) begin
          if (k == n - 1) rep[k].last = 1'b1;
          due_slot_results.push_back(rep[k]);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t make_item(input logic [1:0] op, input logic [7:0] id,
                                         input logic [15:0] ac, input logic [30:0] now);
    in_item_t it;
    it.opcode        = op;
    it.window_id     = id;
    it.auto_close_ms = ac;
    it.now_ms        = now;
    return it;
  endfunction

  // Offers one transaction, with random idle cycles ahead of it, and predicts
  // its results once it is taken. Valid stays high for a following item.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    step_slot_table(it);
  endtask

  // Drains every owed result, then gives a result-less tick time to finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_slot_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fade_time(input logic [15:0] ms);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fade_ms = ms;
  endtask

  // Random transaction on the running clock. Mostly a well-formed stream with
  // time steps scaled to the fade time; now and then the clock rewinds or
  // leaps into the upper half of the 31-bit range.
  function automatic in_item_t next_random_item();
    in_item_t    it;
    logic [31:0] span;
    logic [31:0] d;
    int          jump;
    int          pick;
    span = {16'd0, fade_ms} + 32'd8;
    jump = $urandom_range(0, 199);
    if (jump == 0) begin
      wall_ms = $urandom_range(0, 1000);
    end else if (jump == 1) begin
      wall_ms = $urandom_range(32'h4000_0000, TIME_MAX);
    end else if (jump < 6) begin
      d = $urandom_range(1, span);
      wall_ms = (wall_ms > d) ? wall_ms - d : 32'd0;
    end else if (jump < 30) begin
      wall_ms = wall_ms + $urandom_range(span, 4 * span);
    end else begin
      wall_ms = wall_ms + $urandom_range(0, span / 2);
    end
    if (wall_ms > TIME_MAX) wall_ms = TIME_MAX;

    pick = $urandom_range(0, 99);
    if (pick < 35) it.opcode = OP_OPEN;
    else if (pick < 55) it.opcode = OP_CLOSE;
    else if (pick < 95) it.opcode = OP_TICK;
    else it.opcode = OP_UNUSED;

    // a small id pool so that closes and reopens hit live slots
    it.window_id = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 11))
                                                 : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.auto_close_ms = 16'd0;
    end else if (pick < 80) begin
      d = $urandom_range(1, 2 * span);
      it.auto_close_ms = (d > 32'd65535) ? 16'hFFFF : d[15:0];
    end else begin
      it.auto_close_ms = 16'($urandom_range(0, 65535));
    end
    it.now_ms = wall_ms[30:0];
    return it;
  endfunction

  // Fade-in ramp, reuse of a live id, manual close, empty tick, ignored opcode.
  task automatic test_open_and_fade();
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd0));           // nothing visible
    send_item(make_item(OP_OPEN, 8'hFF, 16'd0, 31'd100));
    send_item(make_item(OP_TICK, 8'd3, 16'hFFFF, 31'd150));      // mid fade-in
    send_item(make_item(OP_OPEN, 8'h00, 16'hFFFF, 31'd150));
    send_item(make_item(OP_OPEN, 8'hFF, 16'd0, 31'd160));        // restarts slot 0
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd360));         // both reach on
    send_item(make_item(OP_CLOSE, 8'h00, 16'd0, 31'd400));
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd450));         // mid fade-out
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd700));         // fade-out ends
    send_item(make_item(OP_CLOSE, 8'd77, 16'd0, 31'd700));       // unknown id
    send_item(make_item(OP_UNUSED, 8'hFF, 16'hFFFF, 31'h7FFF_FFFF));
  endtask

  // Auto-close from on, a clock that steps back, close while fading in.
  task automatic test_close_and_auto_close();
    send_item(make_item(OP_OPEN, 8'd5, 16'd1, 31'd800));
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd1000));
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd1001));        // auto-close fires
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd990));         // elapsed clamps to 0
    send_item(make_item(OP_OPEN, 8'd9, 16'd0, 31'd1100));
    send_item(make_item(OP_CLOSE, 8'd9, 16'd0, 31'd1150));       // fade-out at full alpha
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd1150));
  endtask

  // Fills the table with five slots opened at one early time, so the overwrite
  // sees a tie on the oldest start; then a tick that reports all eight slots.
  task automatic test_full_table_overwrite();
    for (int k = 0; k < 5; k++)
      send_item(make_item(OP_OPEN, 8'(20 + k), 16'd0, 31'd50));
    send_item(make_item(OP_OPEN, 8'd30, 16'd0, 31'd1200));
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd1200));
  endtask

  // Zero fade time ends every fade at once; the widest fade gives slow ramps.
  task automatic test_fade_time_extremes();
    write_fade_time(16'd0);
    send_item(make_item(OP_OPEN, 8'd40, 16'd0, 31'd1300));
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd1300));
    write_fade_time(16'hFFFF);
    send_item(make_item(OP_CLOSE, 8'd40, 16'd0, 31'd1400));
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd30000));
    write_fade_time(16'd1);
    send_item(make_item(OP_TICK, 8'd0, 16'd0, 31'd30001));
  endtask

  // Six chunks of random traffic, each under a new fade time; the idle mix
  // moves from slow receiver to slow sender to none.
  task automatic test_random_traffic();
    logic [15:0] ft;
    wall_ms = 32'd40000;
    for (int c = 0; c < 6; c++) begin
      case (c)
        0: ft = 16'($urandom_range(1, 30));
        1: ft = 16'd200;
        2: ft = 16'hFFFF;
        3: ft = 16'($urandom_range(1, 1000));
        4: ft = 16'd1;
        default: ft = 16'($urandom_range(0, 65535));
      endcase
      write_fade_time(ft);
      send_idle_pct = (c < 2) ? 12 : (c < 4) ? 78 : 0;
      recv_idle_pct = (c < 2) ? 78 : (c < 4) ? 12 : 0;
      for (int k = 0; k < 65; k++) send_item(next_random_item());
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the
  // block backs up and stalls its input.
  task automatic test_output_backpressure();
    write_fade_time(16'd200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int k = 0; k < 30; k++) send_item(next_random_item());
  endtask

  // Receiver: random stalls, plus a counted hold-off whenever one is requested.
  initial begin : receiver
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Result checker: every accepted transaction against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (due_slot_results.size() == 0) begin
        report_mismatch("with none owed, data", 32'(out_data), 32'd0);
      end else begin
        want_res = due_slot_results.pop_front();
        if (out_data.kind != want_res.kind)
          report_mismatch("kind", 32'(out_data.kind), 32'(want_res.kind));
        if (out_data.slot != want_res.slot)
          report_mismatch("slot", 32'(out_data.slot), 32'(want_res.slot));
        if (out_data.shown_id != want_res.shown_id)
          report_mismatch("shown_id", 32'(out_data.shown_id), 32'(want_res.shown_id));
        if (out_data.shown_state != want_res.shown_state)
          report_mismatch("shown_state", 32'(out_data.shown_state),
                          32'(want_res.shown_state));
        if (out_data.alpha_q8 != want_res.alpha_q8)
          report_mismatch("alpha_q8", 32'(out_data.alpha_q8), 32'(want_res.alpha_q8));
        if (out_data.last != want_res.last)
          report_mismatch("last", 32'(out_data.last), 32'(want_res.last));
      end
    end
  end

  initial begin
    errors        = 0;
    results_seen  = 0;
    hold_requests = 0;
    send_idle_pct = 12;
    recv_idle_pct = 78;
    wall_ms       = 32'd0;
    fade_ms       = FADE_RESET;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_id[i]    = 8'd0;
      tbl_mode[i]  = MODE_OFF;
      tbl_start[i] = 31'd0;
      tbl_auto[i]  = 16'd0;
    end
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_open_and_fade();
    test_close_and_auto_close();
    test_full_table_overwrite();
    test_fade_time_extremes();
    test_random_traffic();
    test_output_backpressure();

    wait_idle();
    if (errors == 0) begin
      $display("** overlay_slot_fade_manager: PASSED **");
    end else begin
      $display("** overlay_slot_fade_manager: FAILED **");
    end
    $finish;
  end

endmodule

// ===== overlay_slot_fade_manager.f =====
+incdir+rtl
rtl/osfm_pkg.sv
rtl/osfm_ram.sv
rtl/osfm_div.sv
rtl/overlay_slot_fade_manager.sv
test/testbench.sv
